// ----- hw/rtl/lav_pkg.sv -----
// Shared constants, types and fixed-point helpers of the look-at view matrix core.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package lav_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_COLS      = 4;
  localparam int COL_W         = 2;
  // Normalized magnitudes have their largest component in [2^29, 2^30).
  localparam int UNIT_TOP      = 29;
  localparam int NORM_W        = 30;
  // Root of a sum of three squares of NORM_W-bit values.
  localparam int ROOT_W        = 31;
  localparam int RAD_W         = 2 * ROOT_W;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLS - 1);

  typedef logic signed [DATA_W-1:0] fix_t;

  // Round a value with 2*fb fraction bits back to fb, halves away from zero.
  function automatic logic signed [63:0] round_frac(input logic signed [63:0] v,
                                                    input int unsigned fb);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
    r = (m + (64'd1 << (fb - 1))) >> fb;
    return v[63] ? $signed(64'd0 - r) : $signed(r);
  endfunction

  function automatic fix_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return fix_t'(32'h7fff_ffff);
    end else if (v < -64'sd2147483648) begin
      return fix_t'(32'h8000_0000);
    end
    return fix_t'(v);
  endfunction

endpackage

// ----- hw/rtl/lav_in_if.sv -----
// Input channel of the look-at view matrix core: eye, target and up hint.
// Depends on lav_pkg for the field type.
`timescale 1ns / 1ps

interface lav_in_if;
  logic          valid;
  logic          ready;
  lav_pkg::fix_t eye_x;
  lav_pkg::fix_t eye_y;
  lav_pkg::fix_t eye_z;
  lav_pkg::fix_t target_x;
  lav_pkg::fix_t target_y;
  lav_pkg::fix_t target_z;
  lav_pkg::fix_t upward_x;
  lav_pkg::fix_t upward_y;
  lav_pkg::fix_t upward_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  upward_x, upward_y, upward_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                upward_x, upward_y, upward_z, output ready);
endinterface

// ----- hw/rtl/lav_out_if.sv -----
// Result channel of the look-at view matrix core: one matrix column per word.
// Depends on lav_pkg for the field types.
`timescale 1ns / 1ps

interface lav_out_if;
  logic                      valid;
  logic                      ready;
  logic [lav_pkg::COL_W-1:0] column_index;
  lav_pkg::fix_t             row0_value;
  lav_pkg::fix_t             row1_value;
  lav_pkg::fix_t             row2_value;
  lav_pkg::fix_t             row3_value;
  logic                      last_column;
  logic                      degenerate;

  modport source (output valid, column_index, row0_value, row1_value, row2_value,
                  row3_value, last_column, degenerate, input ready);
  modport sink (input valid, column_index, row0_value, row1_value, row2_value,
                row3_value, last_column, degenerate, output ready);
endinterface

// ----- hw/rtl/lav_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on lav_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module lav_isqrt #(
  parameter int PW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [lav_pkg::RAD_W-1:0]  in_x,
  input  logic [PW-1:0]              in_sb,
  output logic                       out_vld,
  output logic [lav_pkg::ROOT_W-1:0] out_root,
  output logic [PW-1:0]              out_sb
);

  localparam int N     = lav_pkg::ROOT_W;
  localparam int XW    = lav_pkg::RAD_W;
  localparam int REM_W = N + 3;

  logic [REM_W-1:0] rem_r  [N];
  logic [N-1:0]     root_r [N];
  logic [XW-1:0]    x_r    [N];
  logic [PW-1:0]    sb_r   [N];
  logic             vld_r  [N];

  for (genvar g = 0; g < N; g++) begin : g_st
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] rem_nxt;
    logic [N-1:0]     root_in;
    logic [N-1:0]     root_nxt;
    logic [XW-1:0]    x_in;
    logic [PW-1:0]    sb_in;
    logic             vld_in;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = in_x;
      assign sb_in   = in_sb;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign x_in    = x_r[g-1];
      assign sb_in   = sb_r[g-1];
      assign vld_in  = vld_r[g-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], x_in[XW-1-2*g -: 2]};
      trial  = REM_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[N-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        x_r[g]    <= x_in;
        sb_r[g]   <= sb_in;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_sb   = sb_r[N-1];

endmodule

// ----- hw/rtl/lav_div.sv -----
// Pipelined three-lane restoring divider with a shared divisor and a sideband.
// Depends on lav_pkg for the numerator and divisor widths.
`timescale 1ns / 1ps

module lav_div #(
  parameter int QW = lav_pkg::FRAC_BITS_DEF + 1,
  parameter int PW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [lav_pkg::NORM_W-1:0] in_num [3],
  input  logic [lav_pkg::ROOT_W-1:0] in_den,
  input  logic [PW-1:0]              in_sb,
  output logic                       out_vld,
  output logic [QW-1:0]              out_q [3],
  output logic [PW-1:0]              out_sb
);

  localparam int DW   = lav_pkg::ROOT_W;
  localparam int DR_W = DW + 1;

  logic [DR_W-1:0] rem_r [QW][3];
  logic [QW-1:0]   q_r   [QW][3];
  logic [DW-1:0]   den_r [QW];
  logic [PW-1:0]   sb_r  [QW];
  logic            vld_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_st
    logic [DR_W-1:0] rsh     [3];
    logic [DR_W-1:0] rem_nxt [3];
    logic [QW-1:0]   q_in    [3];
    logic [QW-1:0]   q_nxt   [3];
    logic [DW-1:0]   den_in;
    logic [PW-1:0]   sb_in;
    logic            vld_in;

    // The first step takes the whole numerator; it never exceeds the divisor.
    if (g == 0) begin : g_first
      for (genvar k = 0; k < 3; k++) begin : g_ln
        assign rsh[k]  = DR_W'(in_num[k]);
        assign q_in[k] = '0;
      end
      assign den_in = in_den;
      assign sb_in  = in_sb;
      assign vld_in = in_vld;
    end else begin : g_next
      for (genvar k = 0; k < 3; k++) begin : g_ln
        assign rsh[k]  = {rem_r[g-1][k][DR_W-2:0], 1'b0};
        assign q_in[k] = q_r[g-1][k];
      end
      assign den_in = den_r[g-1];
      assign sb_in  = sb_r[g-1];
      assign vld_in = vld_r[g-1];
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        if (rsh[k] >= DR_W'(den_in)) begin
          rem_nxt[k] = rsh[k] - DR_W'(den_in);
          q_nxt[k]   = {q_in[k][QW-2:0], 1'b1};
        end else begin
          rem_nxt[k] = rsh[k];
          q_nxt[k]   = {q_in[k][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          rem_r[g][k] <= rem_nxt[k];
          q_r[g][k]   <= q_nxt[k];
        end
        den_r[g] <= den_in;
        sb_r[g]  <= sb_in;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_sb  = sb_r[QW-1];
  for (genvar k = 0; k < 3; k++) begin : g_out
    assign out_q[k] = q_r[QW-1][k];
  end

endmodule

// ----- hw/rtl/lav_norm.sv -----
// Vector normalizer: magnitude scaling, sum of squares, root and three divides.
// Depends on lav_pkg, lav_isqrt and lav_div.
`timescale 1ns / 1ps

module lav_norm #(
  parameter int IW        = 33,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int PW        = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic signed [IW-1:0]        in_c [3],
  input  logic [PW-1:0]               in_sb,
  output logic                        out_vld,
  output logic signed [FRAC_BITS+1:0] out_u [3],
  output logic                        out_zero,
  output logic [PW-1:0]               out_sb
);

  localparam int NW   = lav_pkg::NORM_W;
  localparam int SA_W = $clog2(IW + NW);
  localparam int WW   = IW + NW;
  localparam int QW   = FRAC_BITS + 1;
  localparam int OW   = FRAC_BITS + 2;

  typedef struct packed {
    logic [PW-1:0] sb;
    logic          zero;
    logic [2:0]    sgn;
    logic [NW-1:0] mn0;
    logic [NW-1:0] mn1;
    logic [NW-1:0] mn2;
  } sq_sb_t;

  typedef struct packed {
    logic [PW-1:0] sb;
    logic          zero;
    logic [2:0]    sgn;
  } dv_sb_t;

  // Stage 1: magnitudes and the largest of them.
  logic [IW-1:0] m1_nxt [3];
  logic [IW-1:0] m1_r   [3];
  logic [IW-1:0] top1_nxt;
  logic [IW-1:0] top1_r;
  logic [2:0]    sgn1_r;
  logic [PW-1:0] sb1_r;
  logic          vld1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_nxt[i] = in_c[i][IW-1] ? (IW'(0) - $unsigned(in_c[i])) : $unsigned(in_c[i]);
    end
    top1_nxt = m1_nxt[0];
    if (m1_nxt[1] > top1_nxt) begin
      top1_nxt = m1_nxt[1];
    end
    if (m1_nxt[2] > top1_nxt) begin
      top1_nxt = m1_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
    if (en) begin
      m1_r   <= m1_nxt;
      top1_r <= top1_nxt;
      sgn1_r <= {in_c[2][IW-1], in_c[1][IW-1], in_c[0][IW-1]};
      sb1_r  <= in_sb;
    end
  end

  // Stage 2: leading one of the largest magnitude gives the common shift.
  int              p2;
  logic            right2_nxt;
  logic [SA_W-1:0] amt2_nxt;
  logic [IW-1:0]   m2_r [3];
  logic            right2_r;
  logic [SA_W-1:0] amt2_r;
  logic            zero2_r;
  logic [2:0]      sgn2_r;
  logic [PW-1:0]   sb2_r;
  logic            vld2_r;

  always_comb begin
    p2 = 0;
    for (int k = 0; k < IW; k++) begin
      if (top1_r[k]) begin
        p2 = k;
      end
    end
    right2_nxt = (p2 >= lav_pkg::UNIT_TOP);
    amt2_nxt   = right2_nxt ? SA_W'(p2 - lav_pkg::UNIT_TOP) : SA_W'(lav_pkg::UNIT_TOP - p2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
    if (en) begin
      m2_r     <= m1_r;
      right2_r <= right2_nxt;
      amt2_r   <= amt2_nxt;
      zero2_r  <= (top1_r == '0);
      sgn2_r   <= sgn1_r;
      sb2_r    <= sb1_r;
    end
  end

  // Stage 3: apply the shift; right shifts drop low bits.
  logic [NW-1:0] mn3_nxt [3];
  logic [NW-1:0] mn3_r   [3];
  logic          zero3_r;
  logic [2:0]    sgn3_r;
  logic [PW-1:0] sb3_r;
  logic          vld3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mn3_nxt[i] = right2_r ? NW'(WW'(m2_r[i]) >> amt2_r) : NW'(WW'(m2_r[i]) << amt2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
    if (en) begin
      mn3_r   <= mn3_nxt;
      zero3_r <= zero2_r;
      sgn3_r  <= sgn2_r;
      sb3_r   <= sb2_r;
    end
  end

  // Stage 4: squares.
  logic [2*NW-1:0] sq4_r [3];
  logic [NW-1:0]   mn4_r [3];
  logic            zero4_r;
  logic [2:0]      sgn4_r;
  logic [PW-1:0]   sb4_r;
  logic            vld4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (en) begin
      vld4_r <= vld3_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= (2*NW)'(mn3_r[i]) * (2*NW)'(mn3_r[i]);
      end
      mn4_r   <= mn3_r;
      zero4_r <= zero3_r;
      sgn4_r  <= sgn3_r;
      sb4_r   <= sb3_r;
    end
  end

  // Stage 5: sum of squares.
  logic [lav_pkg::RAD_W-1:0] sum5_r;
  sq_sb_t                    sq_sb5_r;
  logic                      vld5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (en) begin
      vld5_r <= vld4_r;
    end
    if (en) begin
      sum5_r   <= lav_pkg::RAD_W'(sq4_r[0]) + lav_pkg::RAD_W'(sq4_r[1])
                + lav_pkg::RAD_W'(sq4_r[2]);
      sq_sb5_r <= '{sb: sb4_r, zero: zero4_r, sgn: sgn4_r,
                    mn0: mn4_r[0], mn1: mn4_r[1], mn2: mn4_r[2]};
    end
  end

  logic                       sq_vld;
  logic [lav_pkg::ROOT_W-1:0] sq_root;
  sq_sb_t                     sq_sb;

  lav_isqrt #(
    .PW($bits(sq_sb_t))
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld5_r),
    .in_x    (sum5_r),
    .in_sb   (sq_sb5_r),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_sb  (sq_sb)
  );

  logic [NW-1:0] dv_num [3];
  dv_sb_t        dv_sb_in;
  logic          dv_vld;
  logic [QW-1:0] dv_q [3];
  dv_sb_t        dv_sb;

  assign dv_num[0] = sq_sb.mn0;
  assign dv_num[1] = sq_sb.mn1;
  assign dv_num[2] = sq_sb.mn2;
  assign dv_sb_in  = '{sb: sq_sb.sb, zero: sq_sb.zero, sgn: sq_sb.sgn};

  lav_div #(
    .QW(QW),
    .PW($bits(dv_sb_t))
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (sq_vld),
    .in_num (dv_num),
    .in_den (sq_root),
    .in_sb  (dv_sb_in),
    .out_vld(dv_vld),
    .out_q  (dv_q),
    .out_sb (dv_sb)
  );

  // Stage 6: restore signs; a zero vector gives zero components.
  logic signed [OW-1:0] u6_nxt [3];
  logic signed [OW-1:0] u6_r   [3];
  logic                 zero6_r;
  logic [PW-1:0]        sb6_r;
  logic                 vld6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_sb.zero) begin
        u6_nxt[i] = '0;
      end else if (dv_sb.sgn[i]) begin
        u6_nxt[i] = -$signed(OW'(dv_q[i]));
      end else begin
        u6_nxt[i] = $signed(OW'(dv_q[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else if (en) begin
      vld6_r <= dv_vld;
    end
    if (en) begin
      u6_r    <= u6_nxt;
      zero6_r <= dv_sb.zero;
      sb6_r   <= dv_sb.sb;
    end
  end

  assign out_vld  = vld6_r;
  assign out_u    = u6_r;
  assign out_zero = zero6_r;
  assign out_sb   = sb6_r;

endmodule

// ----- hw/rtl/look_at_view_matrix_core.sv -----
// Look-at view matrix core. Each accepted input word emits four column words on
// the single result channel, so in steady flow it takes one input word per four
// column words handed out.
// Reset (rst_n low, synchronous) clears the valid bits of the pipeline and the
// valid bit and column index of the column buffer; data registers keep
// whatever they hold.
`timescale 1ns / 1ps

module look_at_view_matrix_core #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lav_in_if.sink    in_if,
  lav_out_if.source out_if
);

  // Widths of the intermediate values. A unit component has magnitude up to one,
  // so it needs two bits above the fraction; the true up vector may round one
  // step past that and gets one more.
  localparam int FW  = FRAC_BITS + 2;
  localparam int UW  = FRAC_BITS + 3;
  localparam int PRW = FW + lav_pkg::DATA_W;
  localparam int CW  = PRW + 1;
  localparam int XW  = 2 * FW + 1;
  localparam int SDW = FW + lav_pkg::DATA_W + 2;
  localparam int UDW = UW + lav_pkg::DATA_W + 2;

  typedef logic signed [FW-1:0] unit_t;
  typedef logic signed [UW-1:0] upv_t;

  typedef struct packed {
    lav_pkg::fix_t [2:0] eye;
    lav_pkg::fix_t [2:0] up;
  } fwd_sb_t;

  typedef struct packed {
    lav_pkg::fix_t [2:0] eye;
    unit_t [2:0]         f;
    logic                degen;
  } side_sb_t;

  // The whole pipeline moves as one. It stalls only when its last stage holds
  // a matrix and the column buffer still has columns to hand out, so the next
  // matrix slides into the buffer in the same cycle its last column leaves.
  logic en;
  logic out_fire;
  logic d6_vld_r;
  logic ser_vld_r;
  logic [lav_pkg::COL_W-1:0] col_r;

  assign out_fire    = out_if.valid && out_if.ready;
  assign en          = !d6_vld_r || !ser_vld_r || (out_fire && (col_r == lav_pkg::LAST_COL));
  assign in_if.ready = en;

  // ---------------------------------------------------------------------------
  // Input stage: direction from eye to target, formed exactly in 33 bits.
  // ---------------------------------------------------------------------------
  logic signed [lav_pkg::DATA_W:0] d0_r [3];
  fwd_sb_t                         fsb0_r;
  logic                            v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_if.valid;
    end
    if (en) begin
      d0_r[0] <= (lav_pkg::DATA_W+1)'(in_if.target_x) - (lav_pkg::DATA_W+1)'(in_if.eye_x);
      d0_r[1] <= (lav_pkg::DATA_W+1)'(in_if.target_y) - (lav_pkg::DATA_W+1)'(in_if.eye_y);
      d0_r[2] <= (lav_pkg::DATA_W+1)'(in_if.target_z) - (lav_pkg::DATA_W+1)'(in_if.eye_z);
      fsb0_r  <= '{eye: {in_if.eye_z, in_if.eye_y, in_if.eye_x},
                   up:  {in_if.upward_z, in_if.upward_y, in_if.upward_x}};
    end
  end

  // Forward vector f.
  logic    fa_vld;
  unit_t   fa_u [3];
  logic    fa_zero;
  fwd_sb_t fa_sb;

  lav_norm #(
    .IW       (lav_pkg::DATA_W + 1),
    .FRAC_BITS(FRAC_BITS),
    .PW       ($bits(fwd_sb_t))
  ) u_norm_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v0_r),
    .in_c    (d0_r),
    .in_sb   (fsb0_r),
    .out_vld (fa_vld),
    .out_u   (fa_u),
    .out_zero(fa_zero),
    .out_sb  (fa_sb)
  );

  // ---------------------------------------------------------------------------
  // Cross product f x up: products first, differences in the next stage.
  // ---------------------------------------------------------------------------
  logic signed [PRW-1:0] pr1_r [6];
  lav_pkg::fix_t [2:0]   eye1_r;
  unit_t                 f1_r [3];
  logic                  zero1_r;
  logic                  v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= fa_vld;
    end
    if (en) begin
      pr1_r[0] <= PRW'(fa_u[1]) * PRW'(fa_sb.up[2]);
      pr1_r[1] <= PRW'(fa_u[2]) * PRW'(fa_sb.up[1]);
      pr1_r[2] <= PRW'(fa_u[2]) * PRW'(fa_sb.up[0]);
      pr1_r[3] <= PRW'(fa_u[0]) * PRW'(fa_sb.up[2]);
      pr1_r[4] <= PRW'(fa_u[0]) * PRW'(fa_sb.up[1]);
      pr1_r[5] <= PRW'(fa_u[1]) * PRW'(fa_sb.up[0]);
      eye1_r   <= fa_sb.eye;
      f1_r     <= fa_u;
      zero1_r  <= fa_zero;
    end
  end

  logic signed [CW-1:0] cr2_r [3];
  side_sb_t             ssb2_r;
  logic                 v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      cr2_r[0] <= CW'(pr1_r[0]) - CW'(pr1_r[1]);
      cr2_r[1] <= CW'(pr1_r[2]) - CW'(pr1_r[3]);
      cr2_r[2] <= CW'(pr1_r[4]) - CW'(pr1_r[5]);
      ssb2_r   <= '{eye: eye1_r, f: {f1_r[2], f1_r[1], f1_r[0]}, degen: zero1_r};
    end
  end

  // Side vector s.
  logic     sb_vld;
  unit_t    sb_u [3];
  logic     sb_zero;
  side_sb_t sb_sb;

  lav_norm #(
    .IW       (CW),
    .FRAC_BITS(FRAC_BITS),
    .PW       ($bits(side_sb_t))
  ) u_norm_side (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v2_r),
    .in_c    (cr2_r),
    .in_sb   (ssb2_r),
    .out_vld (sb_vld),
    .out_u   (sb_u),
    .out_zero(sb_zero),
    .out_sb  (sb_sb)
  );

  // ---------------------------------------------------------------------------
  // D1: products of s x f and of the dot products of s and f with the eye.
  // ---------------------------------------------------------------------------
  logic signed [2*FW-1:0] sf1_r [6];
  logic signed [PRW-1:0]  se1_r [3];
  logic signed [PRW-1:0]  fe1_r [3];
  lav_pkg::fix_t [2:0]    eyed1_r;
  unit_t                  sd1_r [3];
  unit_t                  fd1_r [3];
  logic                   deg1_r;
  logic                   vd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd1_r <= 1'b0;
    end else if (en) begin
      vd1_r <= sb_vld;
    end
    if (en) begin
      sf1_r[0] <= (2*FW)'(sb_u[1]) * (2*FW)'(sb_sb.f[2]);
      sf1_r[1] <= (2*FW)'(sb_u[2]) * (2*FW)'(sb_sb.f[1]);
      sf1_r[2] <= (2*FW)'(sb_u[2]) * (2*FW)'(sb_sb.f[0]);
      sf1_r[3] <= (2*FW)'(sb_u[0]) * (2*FW)'(sb_sb.f[2]);
      sf1_r[4] <= (2*FW)'(sb_u[0]) * (2*FW)'(sb_sb.f[1]);
      sf1_r[5] <= (2*FW)'(sb_u[1]) * (2*FW)'(sb_sb.f[0]);
      for (int i = 0; i < 3; i++) begin
        se1_r[i] <= PRW'(sb_u[i]) * PRW'(sb_sb.eye[i]);
        fe1_r[i] <= PRW'(sb_sb.f[i]) * PRW'(sb_sb.eye[i]);
        fd1_r[i] <= sb_sb.f[i];
      end
      eyed1_r <= sb_sb.eye;
      sd1_r   <= sb_u;
      deg1_r  <= sb_sb.degen | sb_zero;
    end
  end

  // D2: differences of the cross product and sums of the dot products.
  logic signed [XW-1:0]  x2_r [3];
  logic signed [SDW-1:0] sdot2_r;
  logic signed [SDW-1:0] fdot2_r;
  lav_pkg::fix_t [2:0]   eyed2_r;
  unit_t                 sd2_r [3];
  unit_t                 fd2_r [3];
  logic                  deg2_r;
  logic                  vd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd2_r <= 1'b0;
    end else if (en) begin
      vd2_r <= vd1_r;
    end
    if (en) begin
      x2_r[0] <= XW'(sf1_r[0]) - XW'(sf1_r[1]);
      x2_r[1] <= XW'(sf1_r[2]) - XW'(sf1_r[3]);
      x2_r[2] <= XW'(sf1_r[4]) - XW'(sf1_r[5]);
      sdot2_r <= SDW'(se1_r[0]) + SDW'(se1_r[1]) + SDW'(se1_r[2]);
      fdot2_r <= SDW'(fe1_r[0]) + SDW'(fe1_r[1]) + SDW'(fe1_r[2]);
      eyed2_r <= eyed1_r;
      sd2_r   <= sd1_r;
      fd2_r   <= fd1_r;
      deg2_r  <= deg1_r;
    end
  end

  // D3: round the true up vector and the first and third translation entries.
  upv_t                ud3_r [3];
  lav_pkg::fix_t       tx0_3_r;
  lav_pkg::fix_t       tx2_3_r;
  lav_pkg::fix_t [2:0] eyed3_r;
  unit_t               sd3_r [3];
  unit_t               fd3_r [3];
  logic                deg3_r;
  logic                vd3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd3_r <= 1'b0;
    end else if (en) begin
      vd3_r <= vd2_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ud3_r[i] <= UW'(lav_pkg::round_frac(64'(x2_r[i]), FRAC_BITS));
      end
      tx0_3_r <= lav_pkg::sat32(-lav_pkg::round_frac(64'(sdot2_r), FRAC_BITS));
      tx2_3_r <= lav_pkg::sat32(lav_pkg::round_frac(64'(fdot2_r), FRAC_BITS));
      eyed3_r <= eyed2_r;
      sd3_r   <= sd2_r;
      fd3_r   <= fd2_r;
      deg3_r  <= deg2_r;
    end
  end

  // D4: products of the true up vector with the eye.
  logic signed [UW+lav_pkg::DATA_W-1:0] ue4_r [3];
  upv_t                                 ud4_r [3];
  lav_pkg::fix_t                        tx0_4_r;
  lav_pkg::fix_t                        tx2_4_r;
  unit_t                                sd4_r [3];
  unit_t                                fd4_r [3];
  logic                                 deg4_r;
  logic                                 vd4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd4_r <= 1'b0;
    end else if (en) begin
      vd4_r <= vd3_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ue4_r[i] <= (UW+lav_pkg::DATA_W)'(ud3_r[i]) * (UW+lav_pkg::DATA_W)'(eyed3_r[i]);
      end
      ud4_r   <= ud3_r;
      tx0_4_r <= tx0_3_r;
      tx2_4_r <= tx2_3_r;
      sd4_r   <= sd3_r;
      fd4_r   <= fd3_r;
      deg4_r  <= deg3_r;
    end
  end

  // D5: sum of that dot product.
  logic signed [UDW-1:0] udot5_r;
  upv_t                  ud5_r [3];
  lav_pkg::fix_t         tx0_5_r;
  lav_pkg::fix_t         tx2_5_r;
  unit_t                 sd5_r [3];
  unit_t                 fd5_r [3];
  logic                  deg5_r;
  logic                  vd5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd5_r <= 1'b0;
    end else if (en) begin
      vd5_r <= vd4_r;
    end
    if (en) begin
      udot5_r <= UDW'(ue4_r[0]) + UDW'(ue4_r[1]) + UDW'(ue4_r[2]);
      ud5_r   <= ud4_r;
      tx0_5_r <= tx0_4_r;
      tx2_5_r <= tx2_4_r;
      sd5_r   <= sd4_r;
      fd5_r   <= fd4_r;
      deg5_r  <= deg4_r;
    end
  end

  // D6: second translation entry; all entries are now 32-bit words.
  lav_pkg::fix_t s6_r  [3];
  lav_pkg::fix_t u6_r  [3];
  lav_pkg::fix_t nf6_r [3];
  lav_pkg::fix_t tx6_r [3];
  logic          deg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d6_vld_r <= 1'b0;
    end else if (en) begin
      d6_vld_r <= vd5_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_r[i]  <= lav_pkg::DATA_W'(sd5_r[i]);
        u6_r[i]  <= lav_pkg::DATA_W'(ud5_r[i]);
        nf6_r[i] <= lav_pkg::DATA_W'(-(FW+1)'(fd5_r[i]));
      end
      tx6_r[0] <= tx0_5_r;
      tx6_r[1] <= lav_pkg::sat32(-lav_pkg::round_frac(64'(udot5_r), FRAC_BITS));
      tx6_r[2] <= tx2_5_r;
      deg6_r   <= deg5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Column buffer: holds one matrix and hands it out a column per word.
  // ---------------------------------------------------------------------------
  lav_pkg::fix_t ser_s_r  [3];
  lav_pkg::fix_t ser_u_r  [3];
  lav_pkg::fix_t ser_nf_r [3];
  lav_pkg::fix_t ser_tx_r [3];
  logic          ser_deg_r;
  logic          load;

  assign load = en && d6_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      col_r     <= '0;
    end else if (load) begin
      ser_vld_r <= 1'b1;
      col_r     <= '0;
    end else if (out_fire) begin
      if (col_r == lav_pkg::LAST_COL) begin
        ser_vld_r <= 1'b0;
        col_r     <= '0;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
    if (load) begin
      ser_s_r   <= s6_r;
      ser_u_r   <= u6_r;
      ser_nf_r  <= nf6_r;
      ser_tx_r  <= tx6_r;
      ser_deg_r <= deg6_r;
    end
  end

  // Columns 0 to 2 carry (s, u, -f, 0); column 3 carries the translation and one.
  always_comb begin
    if (col_r == lav_pkg::LAST_COL) begin
      out_if.row0_value = ser_tx_r[0];
      out_if.row1_value = ser_tx_r[1];
      out_if.row2_value = ser_tx_r[2];
      out_if.row3_value = lav_pkg::fix_t'(lav_pkg::DATA_W'(1) << FRAC_BITS);
    end else begin
      out_if.row0_value = ser_s_r[col_r];
      out_if.row1_value = ser_u_r[col_r];
      out_if.row2_value = ser_nf_r[col_r];
      out_if.row3_value = '0;
    end
  end

  assign out_if.valid        = ser_vld_r;
  assign out_if.column_index = col_r;
  assign out_if.last_column  = (col_r == lav_pkg::LAST_COL);
  assign out_if.degenerate   = ser_deg_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A column that is taken before the last is followed by the next column index.
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_if.last_column) |=>
      (out_if.valid && (out_if.column_index == $past(out_if.column_index) + 1'b1)))
    else $error("column index did not advance by one");

  // The degenerate flag is the same on all four columns of one matrix.
  a_deg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_if.last_column) |=> $stable(out_if.degenerate))
    else $error("degenerate flag changed within a matrix");

  // With nothing waiting behind it, the buffer empties after its last column.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_if.last_column && !d6_vld_r) |=> !out_if.valid)
    else $error("column buffer did not empty after the last column");

  // A new matrix starts at column zero.
  a_load_col0: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_if.valid && (out_if.column_index == '0)))
    else $error("new matrix did not start at column zero");

endmodule
